@@ hw/rtl/salc_pkg.sv @@
// shared types and constants for the set-associative lru cache model
`timescale 1ns / 1ps

package salc_pkg;

  // access kinds (op 3 is treated as a load)
  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_STORE  = 2'd1;
  localparam op_t OP_MODIFY = 2'd2;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SET_BITS    = 2'd0;
  localparam cfg_idx_t CFG_BLOCK_BITS  = 2'd1;
  localparam cfg_idx_t CFG_WAYS_IN_USE = 2'd2;

  localparam int unsigned CFG_DATA_W = 6;

  // configuration reset values
  localparam logic [3:0] SET_BITS_RST   = 4'd4;
  localparam logic [5:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  // block offset bits are held to this range
  localparam logic [5:0] BLOCK_BITS_MAX = 6'd32;

  localparam int unsigned RANK_W  = 4;
  localparam int unsigned TOTAL_W = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic in_load;
    logic decide;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/set_assoc_lru_cache_model_unit.sv @@
// top level of the set-associative lru cache model
`timescale 1ns / 1ps

// Set-associative cache model with LRU replacement: each accepted word (op,
// address) is looked up in its set and answered by one result word with the
// hits it adds, miss and eviction flags and the saturating running totals.
// An access goes in order: the accept cycle reads the set's row from the set
// memory, the next cycle compares tags and picks the way, the write-back step
// writes the row back with the new ranks and loads the output register; no new
// word is taken before the write-back is done. A result word waiting downstream
// holds the block only at the write-back step. After reset a clearing pass walks
// all 2**floor(log2(MAX_SETS)) rows of the set memory (256 by default) one row
// per cycle, with in_ready_o low; configuration writes are taken at
// any time but must only be made while the block is idle.
module set_assoc_lru_cache_model_unit #(
  parameter int unsigned MAX_SETS   = 256,
  parameter int unsigned MAX_WAYS   = 8,
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  salc_pkg::cfg_idx_t              cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // access word
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      op_i,
  input  logic [ADDR_WIDTH-1:0]           address_i,
  // result word
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      hits_added_o,
  output logic                            was_miss_o,
  output logic                            was_eviction_o,
  output logic [salc_pkg::TOTAL_W-1:0]    total_hits_o,
  output logic [salc_pkg::TOTAL_W-1:0]    total_misses_o,
  output logic [salc_pkg::TOTAL_W-1:0]    total_evictions_o
);

  salc_pkg::cmd_t    cmd;
  salc_pkg::status_t status;

  // sequencer: clear pass, accept, lookup, write-back
  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // set memory, lookup logic, totals and output register
  salc_dp #(
    .MAX_SETS   (MAX_SETS),
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .address_i         (address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .hits_added_o      (hits_added_o),
    .was_miss_o        (was_miss_o),
    .was_eviction_o    (was_eviction_o),
    .total_hits_o      (total_hits_o),
    .total_misses_o    (total_misses_o),
    .total_evictions_o (total_evictions_o)
  );

endmodule

@@ hw/rtl/salc_ctrl.sv @@
// controller state machine for the set-associative lru cache model
`timescale 1ns / 1ps

module salc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  salc_pkg::status_t status_i,
  output salc_pkg::cmd_t    cmd_o
);

  salc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= salc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      salc_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = salc_pkg::ST_IDLE;
      end
      salc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = salc_pkg::ST_LOOKUP;
      end
      salc_pkg::ST_LOOKUP: begin
        state_d = salc_pkg::ST_UPDATE;
      end
      salc_pkg::ST_UPDATE: begin
        if (status_i.out_free) state_d = salc_pkg::ST_IDLE;
      end
      default: begin
        state_d = salc_pkg::ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      salc_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      salc_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.in_load = in_valid_i;
      end
      salc_pkg::ST_LOOKUP: begin
        cmd_o.decide = 1'b1;
      end
      salc_pkg::ST_UPDATE: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/salc_dp.sv @@
// datapath of the set-associative lru cache model: config, set memory, lookup, totals
`timescale 1ns / 1ps

module salc_dp #(
  parameter int unsigned MAX_SETS   = 256,
  parameter int unsigned MAX_WAYS   = 8,
  parameter int unsigned ADDR_WIDTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  salc_pkg::cmd_t               cmd_i,
  output salc_pkg::status_t            status_o,
  input  logic                         cfg_we_i,
  input  salc_pkg::cfg_idx_t           cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]                   op_i,
  input  logic [ADDR_WIDTH-1:0]        address_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   hits_added_o,
  output logic                         was_miss_o,
  output logic                         was_eviction_o,
  output logic [salc_pkg::TOTAL_W-1:0] total_hits_o,
  output logic [salc_pkg::TOTAL_W-1:0] total_misses_o,
  output logic [salc_pkg::TOTAL_W-1:0] total_evictions_o
);

  localparam int unsigned SET_W  = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned DEPTH  = 1 << SET_W;
  localparam int unsigned TAG_W  = ADDR_WIDTH - 2;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int unsigned RANK_W = salc_pkg::RANK_W;
  localparam int unsigned TOT_W  = salc_pkg::TOTAL_W;
  localparam logic [3:0]  SET_BITS_MAX = 4'(SET_W);
  localparam logic [4:0]  WAYS_MAX     = 5'(MAX_WAYS);

  // configuration
  logic [3:0] cfg_set_q;
  logic [5:0] cfg_block_q;
  logic [3:0] cfg_ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_set_q   <= salc_pkg::SET_BITS_RST;
      cfg_block_q <= salc_pkg::BLOCK_BITS_RST;
      cfg_ways_q  <= salc_pkg::WAYS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        salc_pkg::CFG_SET_BITS:    cfg_set_q   <= cfg_data_i[3:0];
        salc_pkg::CFG_BLOCK_BITS:  cfg_block_q <= cfg_data_i;
        salc_pkg::CFG_WAYS_IN_USE: cfg_ways_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // clamped configuration
  logic [3:0]       set_eff;
  logic [5:0]       block_eff;
  logic [4:0]       ways_c;
  logic [CNT_W-1:0] ways_eff;
  logic [MAX_WAYS-1:0] in_use;

  always_comb begin
    if (cfg_set_q == 4'd0) set_eff = 4'd1;
    else if (cfg_set_q > SET_BITS_MAX) set_eff = SET_BITS_MAX;
    else set_eff = cfg_set_q;

    if (cfg_block_q == 6'd0) block_eff = 6'd1;
    else if (cfg_block_q > salc_pkg::BLOCK_BITS_MAX) block_eff = salc_pkg::BLOCK_BITS_MAX;
    else block_eff = cfg_block_q;

    if (cfg_ways_q == 4'd0) ways_c = 5'd1;
    else if ({1'b0, cfg_ways_q} > WAYS_MAX) ways_c = WAYS_MAX;
    else ways_c = {1'b0, cfg_ways_q};
    ways_eff = CNT_W'(ways_c);
  end

  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_use
    assign in_use[g] = (CNT_W'(g) < ways_eff);
  end

  // address split
  logic [SET_W-1:0] set_in;
  logic [SET_W-1:0] set_mask;
  logic [6:0]       tag_shift;
  logic [TAG_W-1:0] tag_in;

  always_comb begin
    set_mask  = ~({SET_W{1'b1}} << set_eff);
    set_in    = SET_W'(address_i >> block_eff) & set_mask;
    tag_shift = 7'(set_eff) + 7'(block_eff);
    tag_in    = TAG_W'(address_i >> tag_shift);
  end

  // set memories, one row per set
  logic [MAX_WAYS-1:0]             mem_valid [DEPTH];
  logic [MAX_WAYS-1:0][RANK_W-1:0] mem_rank  [DEPTH];
  logic [MAX_WAYS-1:0][TAG_W-1:0]  mem_tag   [DEPTH];

  logic [SET_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign status_o.clr_last = (clr_cnt_q == {SET_W{1'b1}});

  // item registers and row read
  logic                            modify_q;
  logic [SET_W-1:0]                set_q;
  logic [TAG_W-1:0]                tag_q;
  logic [MAX_WAYS-1:0]             rd_valid_q;
  logic [MAX_WAYS-1:0][RANK_W-1:0] rd_rank_q;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      modify_q   <= (op_i == salc_pkg::OP_MODIFY);
      set_q      <= set_in;
      tag_q      <= tag_in;
      rd_valid_q <= mem_valid[set_in];
      rd_rank_q  <= mem_rank[set_in];
      rd_tag_q   <= mem_tag[set_in];
    end
  end

  // lookup: hit, first empty way, first lowest rank
  logic             hit_found;
  logic [WAY_W-1:0] hit_way;
  logic             empty_found;
  logic [WAY_W-1:0] empty_way;
  logic [WAY_W-1:0] lru_way;
  logic [RANK_W:0]  best;

  always_comb begin
    hit_found   = 1'b0;
    hit_way     = '0;
    empty_found = 1'b0;
    empty_way   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (in_use[i] && rd_valid_q[i] && (rd_tag_q[i] == tag_q)) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(i);
      end
      if (in_use[i] && !rd_valid_q[i]) begin
        empty_found = 1'b1;
        empty_way   = WAY_W'(i);
      end
    end
    best    = '1;
    lru_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && ({1'b0, rd_rank_q[i]} < best)) begin
        best    = {1'b0, rd_rank_q[i]};
        lru_way = WAY_W'(i);
      end
    end
  end

  logic [WAY_W-1:0] way_q;
  logic             miss_q;
  logic             evict_q;
  logic [1:0]       add_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      miss_q  <= !hit_found;
      evict_q <= !hit_found && !empty_found;
      if (hit_found) begin
        way_q <= hit_way;
        add_q <= modify_q ? 2'd2 : 2'd1;
      end else begin
        way_q <= empty_found ? empty_way : lru_way;
        add_q <= modify_q ? 2'd1 : 2'd0;
      end
    end
  end

  // rank update and new row
  logic [RANK_W-1:0]               own_rank;
  logic [RANK_W-1:0]               top_rank;
  logic [MAX_WAYS-1:0]             new_valid;
  logic [MAX_WAYS-1:0][RANK_W-1:0] new_rank;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tag;

  always_comb begin
    own_rank  = rd_rank_q[way_q];
    top_rank  = ways_c[RANK_W-1:0];
    new_valid = rd_valid_q;
    new_rank  = rd_rank_q;
    new_tag   = rd_tag_q;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i]) begin
        if (WAY_W'(i) == way_q) begin
          new_valid[i] = 1'b1;
          new_rank[i]  = top_rank;
          new_tag[i]   = tag_q;
        end else if (rd_valid_q[i] && (rd_rank_q[i] > own_rank)) begin
          new_rank[i] = rd_rank_q[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      mem_valid[clr_cnt_q] <= '0;
      mem_rank[clr_cnt_q]  <= '0;
    end else if (cmd_i.commit) begin
      mem_valid[set_q] <= new_valid;
      mem_rank[set_q]  <= new_rank;
      mem_tag[set_q]   <= new_tag;
    end
  end

  // saturating totals
  logic [TOT_W:0]   hits_sum;
  logic [TOT_W:0]   miss_sum;
  logic [TOT_W:0]   evict_sum;
  logic [TOT_W-1:0] hits_q, misses_q, evicts_q;

  always_comb begin
    hits_sum  = {1'b0, hits_q} + (TOT_W + 1)'(add_q);
    miss_sum  = {1'b0, misses_q} + (TOT_W + 1)'(miss_q);
    evict_sum = {1'b0, evicts_q} + (TOT_W + 1)'(evict_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (cmd_i.commit) begin
      hits_q   <= hits_sum[TOT_W]  ? '1 : hits_sum[TOT_W-1:0];
      misses_q <= miss_sum[TOT_W]  ? '1 : miss_sum[TOT_W-1:0];
      evicts_q <= evict_sum[TOT_W] ? '1 : evict_sum[TOT_W-1:0];
    end
  end

  // output register
  logic       out_valid_q;
  logic [1:0] out_add_q;
  logic       out_miss_q;
  logic       out_evict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_add_q   <= add_q;
      out_miss_q  <= miss_q;
      out_evict_q <= evict_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign hits_added_o      = out_add_q;
  assign was_miss_o        = out_miss_q;
  assign was_eviction_o    = out_evict_q;
  // totals only move on a commit, which needs the previous word taken
  assign total_hits_o      = hits_q;
  assign total_misses_o    = misses_q;
  assign total_evictions_o = evicts_q;

endmodule

@@ hw/rtl/salc_checker.sv @@
// port-level checks for the set-associative lru cache model, bound to the top level
`timescale 1ns / 1ps

module salc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [1:0]                      hits_added_o,
  input logic                            was_miss_o,
  input logic                            was_eviction_o,
  input logic [salc_pkg::TOTAL_W-1:0]    total_hits_o
);

  // an eviction only happens on a miss
  a_evict_needs_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && was_eviction_o) |-> was_miss_o)
    else $error("eviction reported without a miss");

  // a miss adds at most one hit, and never more than two in any case
  a_hits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((hits_added_o != 2'd3) && !(was_miss_o && (hits_added_o == 2'd2))))
    else $error("hits added out of range");

  // one access in flight: no new word is taken right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("word accepted while previous access still in work");

  // a stalled result word stays valid and its total_hits holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(total_hits_o)))
    else $error("result word changed while stalled");

endmodule

bind set_assoc_lru_cache_model_unit salc_checker u_salc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hits_added_o (hits_added_o),
  .was_miss_o   (was_miss_o),
  .was_eviction_o (was_eviction_o),
  .total_hits_o (total_hits_o)
);

@@ sim/tb_set_assoc_lru_cache_model_unit.sv @@
// self-checking testbench for the set-associative lru cache model unit
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_model_unit;

  localparam int unsigned MAX_SETS   = 256;
  localparam int unsigned MAX_WAYS   = 8;
  localparam int unsigned ADDR_WIDTH = 64;
  localparam int unsigned LINES      = MAX_SETS * MAX_WAYS;
  // floor(log2(MAX_SETS)), the widest set index the block accepts
  localparam int unsigned SET_BITS_TOP = $clog2(MAX_SETS + 1) - 1;
  // the fourth op code has no name in the package, it behaves as a load
  localparam salc_pkg::op_t OP_UNUSED = 2'd3;

  // one access word as the sender offers it
  typedef struct {
    salc_pkg::op_t   op;
    logic [63:0]     addr;
  } access_t;

  // one result word, field by field
  typedef struct packed {
    logic [1:0]                   hits_added;
    logic                         was_miss;
    logic                         was_eviction;
    logic [salc_pkg::TOTAL_W-1:0] total_hits;
    logic [salc_pkg::TOTAL_W-1:0] total_misses;
    logic [salc_pkg::TOTAL_W-1:0] total_evictions;
  } result_word_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  salc_pkg::cfg_idx_t              cfg_idx_i = salc_pkg::CFG_SET_BITS;
  logic [salc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [1:0]                      op_i = salc_pkg::OP_LOAD;
  logic [ADDR_WIDTH-1:0]           address_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic [1:0]                      hits_added_o;
  logic                            was_miss_o;
  logic                            was_eviction_o;
  logic [salc_pkg::TOTAL_W-1:0]    total_hits_o;
  logic [salc_pkg::TOTAL_W-1:0]    total_misses_o;
  logic [salc_pkg::TOTAL_W-1:0]    total_evictions_o;

  set_assoc_lru_cache_model_unit #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .address_i        (address_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hits_added_o     (hits_added_o),
    .was_miss_o       (was_miss_o),
    .was_eviction_o   (was_eviction_o),
    .total_hits_o     (total_hits_o),
    .total_misses_o   (total_misses_o),
    .total_evictions_o(total_evictions_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow cache: register copies, line store and running totals
  // ---------------------------------------------------------------------------

  // raw register contents as written, clamping happens per access
  logic [3:0]         cfg_set_bits   = salc_pkg::SET_BITS_RST;
  logic [5:0]         cfg_block_bits = salc_pkg::BLOCK_BITS_RST;
  logic [3:0]         cfg_ways       = salc_pkg::WAYS_RST;

  logic                          line_valid [LINES] = '{default: 1'b0};
  logic [63:0]                   line_tag   [LINES] = '{default: 64'd0};
  logic [salc_pkg::RANK_W-1:0]   line_rank  [LINES] = '{default: '0};
  logic [salc_pkg::TOTAL_W-1:0]  hit_total   = '0;
  logic [salc_pkg::TOTAL_W-1:0]  miss_total  = '0;
  logic [salc_pkg::TOTAL_W-1:0]  evict_total = '0;

  access_t      pending_q [$];
  result_word_t expected_q [$];

  int error_cnt      = 0;
  int items_queued   = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int settings_cnt   = 1;
  int send_gap       = 0;
  int recv_stall     = 0;
  int long_hold      = 0;

  function automatic int unsigned clamp_field(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [salc_pkg::TOTAL_W-1:0] sat_add(
      logic [salc_pkg::TOTAL_W-1:0] total, logic [1:0] n);
    logic [salc_pkg::TOTAL_W:0] sum;
    sum = {1'b0, total} + n;
    return sum[salc_pkg::TOTAL_W] ? '1 : sum[salc_pkg::TOTAL_W-1:0];
  endfunction

  // looks one access up in the shadow cache, updates it and returns the result word
  function automatic result_word_t cache_access(salc_pkg::op_t op, logic [63:0] addr);
    int unsigned  s, b, ways, base, way, i, best;
    logic [63:0]  set_idx, tag;
    logic         found, empty;
    logic [salc_pkg::RANK_W-1:0] own;
    result_word_t r;
    s    = clamp_field(32'(cfg_set_bits), 1, SET_BITS_TOP);
    b    = clamp_field(32'(cfg_block_bits), 1, 32'(salc_pkg::BLOCK_BITS_MAX));
    ways = clamp_field(32'(cfg_ways), 1, MAX_WAYS);
    set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
    // tags are kept at full width
    tag  = addr >> (s + b);
    base = 32'(set_idx) * MAX_WAYS;
    r = '0;
    found = 1'b0;
    way = 0;
    // only the first ways_in_use ways count, whatever older lines lie beyond
    for (i = 0; i < ways && !found; i++) begin
      if (line_valid[base + i] && line_tag[base + i] == tag) begin
        found = 1'b1;
        way = i;
      end
    end
    if (found) begin
      r.hits_added = (op == salc_pkg::OP_MODIFY) ? 2'd2 : 2'd1;
    end else begin
      r.was_miss = 1'b1;
      empty = 1'b0;
      for (i = 0; i < ways && !empty; i++) begin
        if (!line_valid[base + i]) begin
          empty = 1'b1;
          way = i;
        end
      end
      if (!empty) begin
        // lowest rank goes, first way wins a tie (rank 1 may be missing after
        // ways_in_use shrinks)
        r.was_eviction = 1'b1;
        best = 256;
        for (i = 0; i < ways; i++) begin
          if (line_rank[base + i] < best) begin
            best = 32'(line_rank[base + i]);
            way = i;
          end
        end
      end
      line_valid[base + way] = 1'b1;
      line_tag[base + way]   = tag;
      // the store half of a modify always hits after the fill
      if (op == salc_pkg::OP_MODIFY) r.hits_added = 2'd1;
    end
    // move the accessed way to the top, valid ways above it slide down one
    own = line_rank[base + way];
    for (i = 0; i < ways; i++) begin
      if (line_valid[base + i] && line_rank[base + i] > own)
        line_rank[base + i] = line_rank[base + i] - 1'b1;
    end
    line_rank[base + way] = salc_pkg::RANK_W'(ways);
    hit_total   = sat_add(hit_total, r.hits_added);
    miss_total  = sat_add(miss_total, {1'b0, r.was_miss});
    evict_total = sat_add(evict_total, {1'b0, r.was_eviction});
    r.total_hits      = hit_total;
    r.total_misses    = miss_total;
    r.total_evictions = evict_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // access driver: one word from the pending queue at a time, random gaps
  // ---------------------------------------------------------------------------

  logic    drv_hold;
  access_t drv_word;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      drv_hold = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        // word accepted, predict its result now with the current registers
        expected_q.push_back(cache_access(op_i, address_i));
        items_accepted++;
        drv_hold = 1'b0;
        // every 64 words a stretch of 16 goes back to back
        send_gap = (items_accepted % 64 < 16) ? 0 : $urandom_range(0, 19);
      end
      if (!drv_hold) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          drv_word = pending_q.pop_front();
          op_i       <= drv_word.op;
          address_i  <= drv_word.addr;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: checks each word against the oldest prediction
  // ---------------------------------------------------------------------------

  result_word_t want;

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      error_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          error_cnt++;
        end else begin
          want = expected_q.pop_front();
          compare_field("hits_added", want.hits_added, hits_added_o);
          compare_field("was_miss", want.was_miss, was_miss_o);
          compare_field("was_eviction", want.was_eviction, was_eviction_o);
          compare_field("total_hits", want.total_hits, total_hits_o);
          compare_field("total_misses", want.total_misses, total_misses_o);
          compare_field("total_evictions", want.total_evictions, total_evictions_o);
        end
        recv_stall = (results_seen % 64 >= 40 && results_seen % 64 < 56) ? 0 :
                     $urandom_range(0, 19);
        // long back-pressure twice, while the driver still has words queued
        if (results_seen == 150 || results_seen == 450) long_hold = 300;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_ready_i <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_access(input salc_pkg::op_t op, input logic [63:0] addr);
    access_t w;
    w.op   = op;
    w.addr = addr;
    pending_q.push_back(w);
    items_queued++;
  endtask

  // every queued word answered, then a pause for the pipeline to settle
  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // writes all three registers, only called while the block is idle
  task automatic apply_config(input logic [5:0] sb, input logic [5:0] bb, input logic [5:0] w);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= salc_pkg::CFG_SET_BITS;
    cfg_data_i <= sb;
    @(posedge clk_i);
    cfg_idx_i  <= salc_pkg::CFG_BLOCK_BITS;
    cfg_data_i <= bb;
    @(posedge clk_i);
    cfg_idx_i  <= salc_pkg::CFG_WAYS_IN_USE;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_set_bits   = sb[3:0];
    cfg_block_bits = bb;
    cfg_ways       = w[3:0];
    settings_cnt++;
  endtask

  initial begin : stimulus
    int          phase, n;
    int unsigned eff_s, eff_b, eff_w;
    logic [63:0] addr, tag_base, tag, set_sel, off;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, direct mapped: hits, modify hit, unused op, conflicts
    queue_access(salc_pkg::OP_LOAD, 64'd0);
    queue_access(salc_pkg::OP_MODIFY, 64'd0);
    queue_access(salc_pkg::OP_STORE, 64'hF);
    queue_access(salc_pkg::OP_LOAD, '1);
    queue_access(OP_UNUSED, '1);
    queue_access(salc_pkg::OP_MODIFY, 64'h100);
    queue_access(salc_pkg::OP_LOAD, 64'd0);
    wait_drained();

    // zero set and block bits clamp to one, four ways: lru order in set 0
    apply_config(6'd0, 6'd0, 6'd4);
    queue_access(salc_pkg::OP_LOAD, 64'd0);
    queue_access(salc_pkg::OP_LOAD, 64'd4);
    queue_access(salc_pkg::OP_LOAD, 64'd8);
    queue_access(salc_pkg::OP_LOAD, 64'd12);
    queue_access(salc_pkg::OP_STORE, 64'd0);
    queue_access(salc_pkg::OP_LOAD, 64'd16);
    queue_access(salc_pkg::OP_MODIFY, 64'd4);
    wait_drained();

    // every register at its top raw value, clamped to 8 / 32 / 8
    apply_config(6'h3F, 6'h3F, 6'h0F);
    queue_access(salc_pkg::OP_MODIFY, '1);
    queue_access(salc_pkg::OP_LOAD, 64'h8000_0000_0000_0000);
    queue_access(salc_pkg::OP_STORE, '1);
    wait_drained();

    // three ways in set 1, then shrink to two so no way holds rank one
    apply_config(6'h3F, 6'h3F, 6'd3);
    queue_access(salc_pkg::OP_LOAD, (64'd1 << 40) | (64'd1 << 32));
    queue_access(salc_pkg::OP_LOAD, (64'd2 << 40) | (64'd1 << 32));
    queue_access(salc_pkg::OP_LOAD, (64'd3 << 40) | (64'd1 << 32));
    queue_access(salc_pkg::OP_LOAD, (64'd1 << 40) | (64'd1 << 32));
    queue_access(salc_pkg::OP_LOAD, (64'd2 << 40) | (64'd1 << 32));
    wait_drained();
    apply_config(6'h3F, 6'h3F, 6'd2);
    // first miss evicts the lower of ranks 2 and 3, the second breaks a tie
    queue_access(salc_pkg::OP_LOAD, (64'd20 << 40) | (64'd1 << 32));
    queue_access(salc_pkg::OP_LOAD, (64'd21 << 40) | (64'd1 << 32));
    wait_drained();

    // random phases, each under its own setting; most addresses reuse a
    // small pool of tags and sets so that hits and evictions are frequent
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          apply_config(6'd1, 6'd1, 6'd1);
        end
        1: begin
          apply_config(6'd8, 6'd32, 6'd8);
        end
        2: begin
          apply_config(6'd2, 6'd5, 6'd2);
        end
        3: begin
          apply_config(6'd0, 6'd0, 6'd0);
        end
        4: begin
          apply_config(6'd12, 6'd50, 6'd12);
        end
        default: begin
          apply_config(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                       6'($urandom_range(0, 63)));
        end
      endcase
      eff_s = clamp_field(32'(cfg_set_bits), 1, SET_BITS_TOP);
      eff_b = clamp_field(32'(cfg_block_bits), 1, 32'(salc_pkg::BLOCK_BITS_MAX));
      eff_w = clamp_field(32'(cfg_ways), 1, MAX_WAYS);
      tag_base = {$urandom, $urandom} >> (eff_s + eff_b);
      for (n = 0; n < 80; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          addr = {$urandom, $urandom};
        end else begin
          tag     = tag_base ^ 64'($urandom_range(0, 2 * eff_w + 1));
          set_sel = 64'($urandom_range(0, 3)) & ((64'd1 << eff_s) - 64'd1);
          off     = {$urandom, $urandom} & ((64'd1 << eff_b) - 64'd1);
          addr    = (tag << (eff_s + eff_b)) | (set_sel << eff_b) | off;
        end
        queue_access(salc_pkg::op_t'($urandom_range(0, 3)), addr);
      end
      wait_drained();
    end

    if (expected_q.size() != 0) begin
      $error("%0d predicted result words never arrived", expected_q.size());
      error_cnt++;
    end
    $display("ran %0d accesses under %0d register settings, out-of-range values included",
             items_accepted, settings_cnt);
    $display("totals reached %0d hits, %0d misses, %0d evictions",
             hit_total, miss_total, evict_total);
    if (error_cnt == 0) begin
      $display("tb_set_assoc_lru_cache_model_unit: clean");
    end else begin
      $display("tb_set_assoc_lru_cache_model_unit: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("timeout with %0d of %0d result words seen", results_seen, items_queued);
    $display("tb_set_assoc_lru_cache_model_unit: errors");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/salc_pkg.sv
hw/rtl/salc_ctrl.sv
hw/rtl/salc_dp.sv
hw/rtl/set_assoc_lru_cache_model_unit.sv
hw/rtl/salc_checker.sv
sim/tb_set_assoc_lru_cache_model_unit.sv
